>>> hdl/dsc_pkg.sv
`default_nettype none
package dsc_pkg;

	// Bytes in one compact component (R or S)
	localparam int COMPONENT_BYTES = 32;
	// Counter width: holds a declared length up to COMPONENT_BYTES + 1
	localparam int CNT_W = $clog2(COMPONENT_BYTES + 2);
	// Largest integer length accepted, one leading zero included
	localparam logic [7:0] LEN_MAX = 8'(COMPONENT_BYTES + 1);
	// Recovery byte base value; bit 0 of the first DER byte is added
	localparam logic [7:0] RECOVERY_BASE = 8'd31;

	typedef logic [CNT_W-1:0] cnt_t;

	// Parse phases, plus the two output burst states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEQLEN,
		ST_TAG,
		ST_LEN,
		ST_FIRST,
		ST_BODY,
		ST_PAD,
		ST_HOLD,
		ST_DONE
	} dsc_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic start_frame;  // clear parse state, emit recovery byte
		logic load_len;     // latch declared integer length
		logic load_first;   // latch first content byte, pad count, remaining
		logic emit_err;     // emit error result
		logic emit_data;    // emit body byte, count down remaining
		logic emit_pad;     // emit one zero pad byte
		logic emit_hold;    // emit the latched first content byte
		logic set_second;   // move on to the S integer
	} dsc_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic slot_free;    // output register can take a result this cycle
		logic len_bad;      // declared length is zero or too long
		logic eff_bad;      // effective length exceeds the component size
		logic pad_zero;     // no pad bytes left
		logic first_nz;     // latched first content byte is nonzero
		logic rem_zero;     // no content bytes remaining
		logic rem_one;      // one content byte remaining
		logic second;       // parsing S
	} dsc_sts_t;

endpackage
`default_nettype wire

>>> hdl/dsc_datapath.sv
`default_nettype none
module dsc_datapath
	import dsc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire dsc_cmd_t   cmd,
	input  wire logic [7:0] data_byte,
	input  wire logic       out_ready,
	output dsc_sts_t        sts,
	output logic            out_valid,
	output logic [7:0]      out_byte,
	output logic            last,
	output logic            error
);

	cnt_t       rem_q;
	cnt_t       pad_q;
	logic       second_q;
	logic       first_nz_q;
	logic [7:0] first_byte_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q;
	logic       error_q;

	cnt_t       eff;
	logic       data_zero;
	logic       emit;
	logic [7:0] nxt_byte;
	logic       nxt_last;
	logic       nxt_err;

	// Effective length after dropping one leading zero byte
	assign data_zero = (data_byte == 8'd0);
	assign eff       = data_zero ? (rem_q - cnt_t'(1)) : rem_q;

	// Status toward the controller
	always_comb begin
		sts.slot_free = !out_valid_q || out_ready;
		sts.len_bad   = data_zero || (data_byte > LEN_MAX);
		sts.eff_bad   = eff > cnt_t'(COMPONENT_BYTES);
		sts.pad_zero  = (pad_q == cnt_t'(0));
		sts.first_nz  = first_nz_q;
		sts.rem_zero  = (rem_q == cnt_t'(0));
		sts.rem_one   = (rem_q == cnt_t'(1));
		sts.second    = second_q;
	end

	// Select the result to load into the output register
	assign emit = cmd.start_frame || cmd.emit_err || cmd.emit_data ||
		cmd.emit_pad || cmd.emit_hold;

	always_comb begin
		nxt_byte = 8'd0;
		nxt_last = 1'b0;
		nxt_err  = 1'b0;
		if (cmd.start_frame) begin
			nxt_byte = RECOVERY_BASE + {7'd0, data_byte[0]};
		end else if (cmd.emit_err) begin
			nxt_last = 1'b1;
			nxt_err  = 1'b1;
		end else if (cmd.emit_data) begin
			nxt_byte = data_byte;
			nxt_last = second_q && (rem_q == cnt_t'(1));
		end else if (cmd.emit_pad) begin
			nxt_last = second_q && !first_nz_q && (rem_q == cnt_t'(0)) &&
				(pad_q == cnt_t'(1));
		end else if (cmd.emit_hold) begin
			nxt_byte = first_byte_q;
			nxt_last = second_q && (rem_q == cnt_t'(0));
		end
	end

	// Parse registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q    <= '0;
			pad_q    <= '0;
			second_q <= 1'b0;
		end else begin
			if (cmd.start_frame) begin
				rem_q    <= '0;
				pad_q    <= '0;
				second_q <= 1'b0;
			end else begin
				if (cmd.load_len) begin
					rem_q <= cnt_t'(data_byte);
				end else if (cmd.load_first) begin
					rem_q <= data_zero ? eff : (eff - cnt_t'(1));
					pad_q <= cnt_t'(COMPONENT_BYTES) - eff;
				end else if (cmd.emit_data && rem_q != cnt_t'(0)) begin
					rem_q <= rem_q - cnt_t'(1);
				end
				if (cmd.emit_pad) begin
					pad_q <= pad_q - cnt_t'(1);
				end
				if (cmd.set_second) begin
					second_q <= 1'b1;
				end
			end
		end
	end

	// Hold the first content byte for after the padding
	always_ff @(posedge clk) begin
		if (cmd.load_first) begin
			first_byte_q <= data_byte;
			first_nz_q   <= !data_zero;
		end
	end

	// Output register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= nxt_byte;
			last_q     <= nxt_last;
			error_q    <= nxt_err;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;
	assign error     = error_q;

endmodule
`default_nettype wire

>>> hdl/dsc_ctrl.sv
`default_nettype none
module dsc_ctrl
	import dsc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     frame_start,
	input  wire dsc_sts_t sts,
	output logic          in_ready,
	output dsc_cmd_t      cmd
);

	dsc_state_t state_q;
	dsc_state_t state_nxt;
	logic       in_fire;
	logic       parse_st;

	// Take input only in parse phases with room in the output register
	assign parse_st = (state_q != ST_PAD) && (state_q != ST_HOLD);
	assign in_ready = parse_st && sts.slot_free;
	assign in_fire  = in_valid && in_ready;

	// Next state
	always_comb begin
		state_nxt = state_q;
		if (in_fire && frame_start) begin
			state_nxt = ST_SEQLEN;
		end else begin
			unique case (state_q)
				ST_IDLE, ST_DONE: begin
					state_nxt = state_q;
				end
				ST_SEQLEN: begin
					if (in_fire) state_nxt = ST_TAG;
				end
				ST_TAG: begin
					if (in_fire) state_nxt = ST_LEN;
				end
				ST_LEN: begin
					if (in_fire) state_nxt = sts.len_bad ? ST_DONE : ST_FIRST;
				end
				ST_FIRST: begin
					if (in_fire) state_nxt = sts.eff_bad ? ST_DONE : ST_PAD;
				end
				ST_BODY: begin
					if (in_fire && sts.rem_one) begin
						state_nxt = sts.second ? ST_DONE : ST_TAG;
					end
				end
				ST_PAD: begin
					if (sts.pad_zero) begin
						if (sts.first_nz) begin
							state_nxt = ST_HOLD;
						end else if (sts.rem_zero) begin
							state_nxt = sts.second ? ST_DONE : ST_TAG;
						end else begin
							state_nxt = ST_BODY;
						end
					end
				end
				ST_HOLD: begin
					if (sts.slot_free) begin
						if (sts.rem_zero) begin
							state_nxt = sts.second ? ST_DONE : ST_TAG;
						end else begin
							state_nxt = ST_BODY;
						end
					end
				end
				default: begin
					state_nxt = ST_IDLE;
				end
			endcase
		end
	end

	// Datapath commands
	always_comb begin
		cmd = '0;
		if (in_fire && frame_start) begin
			cmd.start_frame = 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE, ST_DONE, ST_SEQLEN, ST_TAG: begin
					cmd = '0;
				end
				ST_LEN: begin
					cmd.emit_err = in_fire && sts.len_bad;
					cmd.load_len = in_fire && !sts.len_bad;
				end
				ST_FIRST: begin
					cmd.emit_err   = in_fire && sts.eff_bad;
					cmd.load_first = in_fire && !sts.eff_bad;
				end
				ST_BODY: begin
					cmd.emit_data  = in_fire;
					cmd.set_second = in_fire && sts.rem_one && !sts.second;
				end
				ST_PAD: begin
					cmd.emit_pad   = !sts.pad_zero && sts.slot_free;
					cmd.set_second = sts.pad_zero && !sts.first_nz &&
						sts.rem_zero && !sts.second;
				end
				ST_HOLD: begin
					cmd.emit_hold  = sts.slot_free;
					cmd.set_second = sts.slot_free && sts.rem_zero && !sts.second;
				end
				default: begin
					cmd = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

>>> hdl/der_signature_to_compact.sv
// DER to compact ECDSA signature converter.
// Input channel (in_valid/in_ready): one DER byte per request in data_byte;
// frame_start marks the first byte of a signature and always restarts the
// parse. Output channel (out_valid/out_ready): 65 bytes per frame, recovery
// byte (31 + bit 0 of the first DER byte), then R and S each zero padded to
// 32 bytes; last marks the final byte. A zero or overlong integer length
// gives one request with error and last set and out_byte zero, and the rest
// of the frame is ignored until the next frame_start.
// A result is loaded into the output register in the cycle after the
// request that causes it. Throughput: one input byte per cycle while the
// output register has room, but after the first content byte of each
// integer (held when nonzero, dropped as a leading zero) input waits while
// the controller emits the zero padding (pad = 32 minus the effective
// length) and any held byte, one output byte per cycle while the receiver
// takes them. A stalled receiver holds the output register; input is taken
// while the output register is empty or being drained in the same cycle.
// Reset clears the parser to wait for a frame start and empties the output.
`default_nettype none
module der_signature_to_compact
	import dsc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       frame_start,
	input  wire logic [7:0] data_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            last,
	output logic            error
);

	dsc_cmd_t cmd;
	dsc_sts_t sts;

	dsc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.frame_start (frame_start),
		.sts         (sts),
		.in_ready    (in_ready),
		.cmd         (cmd)
	);

	dsc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (data_byte),
		.out_ready (out_ready),
		.sts       (sts),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.last      (last),
		.error     (error)
	);

endmodule
`default_nettype wire

>>> hdl/dsc_checker.sv
`default_nettype none
module dsc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       frame_start,
	input wire logic [7:0] data_byte,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       last,
	input wire logic       error
);

	// Stalled output request keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
			$stable(last) && $stable(error))
		else $error("output request changed while stalled");

	// An error request always ends the frame
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> last)
		else $error("error request without last");

	// An error request carries a zero byte
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> out_byte == 8'd0)
		else $error("error request with nonzero byte");

	// A frame start is answered next cycle by the recovery byte
	a_recovery: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && frame_start |=> out_valid && !last && !error &&
			out_byte == ($past(data_byte[0]) ? 8'd32 : 8'd31))
		else $error("missing or wrong recovery byte");

endmodule

bind der_signature_to_compact dsc_checker u_dsc_checker (.*);
`default_nettype wire
